### src/ili_pkg.sv
`timescale 1ns / 1ps

package ili_pkg;

    // Field widths of the beats on both channels.
    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 8;

    // Default list capacity.
    localparam int DEF_DEPTH = 128;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd4;
    localparam logic [OP_W-1:0] OP_READ   = 3'd5;

    // Status codes.
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // What the sequencer has to do for one accepted beat.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_WRITE,
        ACT_INS_SHIFT,
        ACT_DEL_SHIFT,
        ACT_READ
    } action_t;

    typedef struct packed {
        logic [ST_W-1:0] status;
        action_t         action;
        logic            at_end;
        logic            cnt_inc;
        logic            cnt_dec;
        logic            cnt_clr;
    } plan_t;

endpackage

### src/ili_decode.sv
`timescale 1ns / 1ps

module ili_decode #(
    parameter int DEPTH = ili_pkg::DEF_DEPTH
) (
    input  logic [ili_pkg::OP_W-1:0]     operation,
    input  logic [ili_pkg::POS_W-1:0]    position,
    input  logic [$clog2(DEPTH+1)-1:0]   count,
    output ili_pkg::plan_t               plan
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > ili_pkg::POS_W) ? CW : ili_pkg::POS_W;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic          full;

    // Bring position and count to a common width for the range checks.
    assign pos_x = XW'(position);
    assign cnt_x = XW'(count);
    assign full  = (count == CW'(DEPTH));

    // Range and capacity checks, and the work each operation needs.
    always_comb
    begin
        plan         = '0;
        plan.status  = ili_pkg::ST_DONE;
        plan.action  = ili_pkg::ACT_NONE;
        unique case (operation)
            ili_pkg::OP_CLEAR:
            begin
                plan.cnt_clr = 1'b1;
            end
            ili_pkg::OP_APPEND:
            begin
                if (full)
                begin
                    plan.status = ili_pkg::ST_FULL;
                end
                else
                begin
                    plan.action  = ili_pkg::ACT_WRITE;
                    plan.at_end  = 1'b1;
                    plan.cnt_inc = 1'b1;
                end
            end
            ili_pkg::OP_INSERT:
            begin
                if (pos_x > cnt_x)
                begin
                    plan.status = ili_pkg::ST_RANGE;
                end
                else if (full)
                begin
                    plan.status = ili_pkg::ST_FULL;
                end
                else
                begin
                    plan.cnt_inc = 1'b1;
                    plan.action  = (pos_x == cnt_x) ? ili_pkg::ACT_WRITE
                                                    : ili_pkg::ACT_INS_SHIFT;
                end
            end
            ili_pkg::OP_UPDATE:
            begin
                if (pos_x >= cnt_x)
                begin
                    plan.status = ili_pkg::ST_RANGE;
                end
                else
                begin
                    plan.action = ili_pkg::ACT_WRITE;
                end
            end
            ili_pkg::OP_DELETE:
            begin
                if (pos_x >= cnt_x)
                begin
                    plan.status = ili_pkg::ST_RANGE;
                end
                else
                begin
                    plan.cnt_dec = 1'b1;
                    plan.action  = (pos_x == cnt_x - XW'(1)) ? ili_pkg::ACT_NONE
                                                             : ili_pkg::ACT_DEL_SHIFT;
                end
            end
            ili_pkg::OP_READ:
            begin
                if (pos_x >= cnt_x)
                begin
                    plan.status = ili_pkg::ST_RANGE;
                end
                else
                begin
                    plan.action = ili_pkg::ACT_READ;
                end
            end
            default:
            begin
                plan.status = ili_pkg::ST_DONE;
            end
        endcase
    end

endmodule

### src/indexed_list_insert_delete.sv
// Clear, ignored codes, rejected beats and a delete of the last entry go straight to the
// completion state; append, update, read and an insert at the end pass through a write or read
// state first; a shifting insert or delete moves one entry per shift step, then passes the tail
// state, and an insert then writes the new value. One beat is worked on at a time; the next is
// accepted from the edge after the result is raised, and a stalled result holds the following
// beat in completion. Reset clears the count, control and output registers, not the list memory.
`timescale 1ns / 1ps

module indexed_list_insert_delete #(
    parameter int DEPTH = ili_pkg::DEF_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ili_pkg::OP_W-1:0]         operation,
    input  logic [ili_pkg::POS_W-1:0]        position,
    input  logic signed [ili_pkg::DATA_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ili_pkg::ST_W-1:0]         status,
    output logic signed [ili_pkg::DATA_W-1:0] read_value,
    output logic [ili_pkg::LEN_W-1:0]        length
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_TAIL,
        S_WRITE,
        S_READ,
        S_DONE
    } state_t;

    state_t                       state_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [AW-1:0]                ptr_reg;
    logic [AW-1:0]                end_reg;
    logic [AW-1:0]                fa_reg;
    logic [AW-1:0]                wa_reg;
    logic                         pend_reg;
    logic                         ins_reg;
    logic [ili_pkg::DATA_W-1:0]   value_reg;
    logic [ili_pkg::ST_W-1:0]     st_reg;
    logic                         is_rd_reg;
    logic [ili_pkg::DATA_W-1:0]   rdata_reg;
    logic                         out_valid_reg;
    logic [ili_pkg::ST_W-1:0]     status_reg;
    logic [ili_pkg::DATA_W-1:0]   rv_reg;
    logic [ili_pkg::LEN_W-1:0]    len_reg;

    logic [ili_pkg::DATA_W-1:0]   mem [DEPTH];

    ili_pkg::plan_t               plan;
    logic                         accept;
    logic                         out_free;
    logic                         rd_en;
    logic                         we;
    logic [AW-1:0]                waddr;
    logic [ili_pkg::DATA_W-1:0]   wdata;
    logic [AW-1:0]                pos_a;
    logic [AW-1:0]                last_a;

    // Checks and operation decode for the incoming beat.
    ili_decode #(
        .DEPTH (DEPTH)
    ) u_decode (
        .operation (operation),
        .position  (position),
        .count     (count_reg),
        .plan      (plan)
    );

    // Handshake and helper addresses.
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign pos_a    = AW'(position);
    assign last_a   = AW'(count_reg - CW'(1));

    always_comb
    begin
        count_next = count_reg;
        if (plan.cnt_clr)
        begin
            count_next = '0;
        end
        else if (plan.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (plan.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Memory port control: a moved entry is written in the cycle after its read.
    assign rd_en = (state_reg == S_SHIFT) || (state_reg == S_READ);
    assign we    = pend_reg || (state_reg == S_WRITE);
    assign waddr = pend_reg ? wa_reg : fa_reg;
    assign wdata = pend_reg ? rdata_reg : value_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[ptr_reg];
        end
    end

    // Sequencer with the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            end_reg       <= '0;
            fa_reg        <= '0;
            wa_reg        <= '0;
            pend_reg      <= 1'b0;
            ins_reg       <= 1'b0;
            value_reg     <= '0;
            st_reg        <= ili_pkg::ST_DONE;
            is_rd_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= ili_pkg::ST_DONE;
            rv_reg        <= '0;
            len_reg       <= '0;
        end
        else
        begin
            pend_reg <= (state_reg == S_SHIFT);

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= count_next;
                        value_reg <= value;
                        st_reg    <= plan.status;
                        is_rd_reg <= (plan.action == ili_pkg::ACT_READ);
                        fa_reg    <= plan.at_end ? AW'(count_reg) : pos_a;
                        unique case (plan.action)
                            ili_pkg::ACT_WRITE:
                            begin
                                state_reg <= S_WRITE;
                            end
                            ili_pkg::ACT_INS_SHIFT:
                            begin
                                ins_reg   <= 1'b1;
                                ptr_reg   <= last_a;
                                end_reg   <= pos_a;
                                state_reg <= S_SHIFT;
                            end
                            ili_pkg::ACT_DEL_SHIFT:
                            begin
                                ins_reg   <= 1'b0;
                                ptr_reg   <= pos_a + AW'(1);
                                end_reg   <= last_a;
                                state_reg <= S_SHIFT;
                            end
                            ili_pkg::ACT_READ:
                            begin
                                ptr_reg   <= pos_a;
                                state_reg <= S_READ;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SHIFT:
                begin
                    // Read at the pointer; the entry lands one place up or down.
                    wa_reg <= ins_reg ? (ptr_reg + AW'(1)) : (ptr_reg - AW'(1));
                    if (ptr_reg == end_reg)
                    begin
                        state_reg <= S_TAIL;
                    end
                    else
                    begin
                        ptr_reg <= ins_reg ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
                    end
                end
                S_TAIL:
                begin
                    state_reg <= ins_reg ? S_WRITE : S_DONE;
                end
                S_WRITE:
                begin
                    state_reg <= S_DONE;
                end
                S_READ:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= st_reg;
                        rv_reg        <= is_rd_reg ? rdata_reg : '0;
                        len_reg       <= ili_pkg::LEN_W'(count_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = rv_reg;
    assign length     = len_reg;

`ifndef SYNTHESIS
    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("list count above capacity");

    // A moved entry is never written to the entry being read in the same cycle.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && state_reg == S_SHIFT) |-> (wa_reg != ptr_reg))
        else $error("shift write collides with shift read");

    // A new result beat only ever comes out of the completion state.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside completion");

    // A rejected beat carries a zero value.
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ili_pkg::ST_DONE) |-> (rv_reg == '0))
        else $error("rejected beat carries a read value");
`endif

endmodule

### test/indexed_list_insert_delete_tb.sv
`timescale 1ns / 1ps

module indexed_list_insert_delete_tb;

    // Widths and codes taken from the package.
    localparam int OP_W   = ili_pkg::OP_W;
    localparam int POS_W  = ili_pkg::POS_W;
    localparam int DATA_W = ili_pkg::DATA_W;
    localparam int ST_W   = ili_pkg::ST_W;
    localparam int LEN_W  = ili_pkg::LEN_W;

    localparam logic [OP_W-1:0] OP_CLEAR  = ili_pkg::OP_CLEAR;
    localparam logic [OP_W-1:0] OP_APPEND = ili_pkg::OP_APPEND;
    localparam logic [OP_W-1:0] OP_INSERT = ili_pkg::OP_INSERT;
    localparam logic [OP_W-1:0] OP_UPDATE = ili_pkg::OP_UPDATE;
    localparam logic [OP_W-1:0] OP_DELETE = ili_pkg::OP_DELETE;
    localparam logic [OP_W-1:0] OP_READ   = ili_pkg::OP_READ;

    localparam logic [ST_W-1:0] ST_DONE  = ili_pkg::ST_DONE;
    localparam logic [ST_W-1:0] ST_RANGE = ili_pkg::ST_RANGE;
    localparam logic [ST_W-1:0] ST_FULL  = ili_pkg::ST_FULL;

    localparam int DEPTH       = ili_pkg::DEF_DEPTH;
    localparam int CLK_PERIOD  = 10;
    localparam int DIR_ROWS    = 24;
    localparam int RAND_PHASES = 11;
    localparam int PHASE_ITEMS = 86;
    localparam int LONG_HOLD   = 300;
    localparam int IDLE_LIMIT  = 2000;

    // The two operation codes that the block ignores.
    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

    // Bias of the random phases.
    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIXED  = 2;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]  length;
    } list_reply_t;

    // One row of the directed table; the reply fields only count when known is set.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        logic              known;
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]  length;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          operation = '0;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         length;

    // Shadow copy of the list, advanced once per accepted input beat.
    logic [DATA_W-1:0] shadow_entries [0:DEPTH-1];
    int                shadow_len = 0;

    list_reply_t replies_due [$];
    dir_row_t    dir_table [0:DIR_ROWS-1];
    int          mismatch_count = 0;
    int          burst_left = 0;
    int          hold_reqs = 0;
    int          hold_seen = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    indexed_list_insert_delete #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .read_value (read_value),
        .length     (length)
    );

    // Work out the reply to one operation and update the shadow list.
    task automatic compute_list_reply(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                      input logic [DATA_W-1:0] val, output list_reply_t reply);
        int idx;
        int at;
        at = int'(pos);
        reply.status     = ST_DONE;
        reply.read_value = '0;
        case (op)
            OP_CLEAR:
                shadow_len = 0;
            OP_APPEND:
                if (shadow_len >= DEPTH)
                    reply.status = ST_FULL;
                else
                begin
                    shadow_entries[shadow_len] = val;
                    shadow_len++;
                end
            OP_INSERT:
                if (at > shadow_len)
                    reply.status = ST_RANGE;
                else if (shadow_len >= DEPTH)
                    reply.status = ST_FULL;
                else
                begin
                    for (idx = shadow_len; idx > at; idx--)
                        shadow_entries[idx] = shadow_entries[idx - 1];
                    shadow_entries[at] = val;
                    shadow_len++;
                end
            OP_UPDATE:
                if (at >= shadow_len)
                    reply.status = ST_RANGE;
                else
                    shadow_entries[at] = val;
            OP_DELETE:
                if (at >= shadow_len)
                    reply.status = ST_RANGE;
                else
                begin
                    for (idx = at; idx + 1 < shadow_len; idx++)
                        shadow_entries[idx] = shadow_entries[idx + 1];
                    shadow_len--;
                end
            OP_READ:
                if (at >= shadow_len)
                    reply.status = ST_RANGE;
                else
                    reply.read_value = shadow_entries[at];
            default:
                ;
        endcase
        reply.length = LEN_W'(shadow_len);
    endtask

    // Offer one beat and return at the edge that accepts it. Bursts of random
    // length are separated by random gaps with valid low.
    task automatic drive_beat(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 10);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        operation <= op;
        position  <= pos;
        value     <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_checked(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
        list_reply_t reply;
        drive_beat(op, pos, val);
        compute_list_reply(op, pos, val, reply);
        replies_due.push_back(reply);
    endtask

    // Compare every accepted output beat with the oldest reply waiting.
    always @(posedge clk)
    begin : reply_check
        list_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t ns: result beat with none waiting: status %0d, read_value %0d, length %0d",
                         $time, status, read_value, length);
                mismatch_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t ns: status mismatch, expected %0d, actual %0d",
                             $time, want.status, status);
                    mismatch_count++;
                end
                if (read_value !== want.read_value)
                begin
                    $display("%0t ns: read_value mismatch, expected %0d, actual %0d",
                             $time, $signed(want.read_value), read_value);
                    mismatch_count++;
                end
                if (length !== want.length)
                begin
                    $display("%0t ns: length mismatch, expected %0d, actual %0d",
                             $time, want.length, length);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver: alternating stall and release runs, quiet stretches, and a long
    // hold-off whenever the stimulus asks for one.
    initial
    begin : receiver
        int  run_left;
        int  hold_left;
        logic stall_now;
        run_left  = 0;
        hold_left = 0;
        stall_now = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    if ($urandom_range(0, 9) < 3)
                    begin
                        stall_now = 1'b0;
                        run_left  = $urandom_range(20, 60);
                    end
                    else
                    begin
                        stall_now = ~stall_now;
                        run_left  = $urandom_range(1, 6);
                    end
                end
                run_left--;
                out_stall <= stall_now;
            end
        end
    end

    // End the run when neither channel has moved a beat for too long.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("%0t ns: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("** indexed_list_insert_delete: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t          row;
        list_reply_t       reply;
        int                k;
        int                phase;
        int                mode;
        int                roll;
        int                lim;
        int                c_app, c_ins, c_upd, c_del, c_rd, c_clr;
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;

        // Directed table: empty list, both ends of the value range, inserts at
        // the front, middle and end, out-of-range indices and the ignored codes.
        dir_table[0]  = '{OP_READ,     7'd0,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 8'd0};
        dir_table[1]  = '{OP_UPDATE,   7'd0,   32'h0000_0005, 1'b1, ST_RANGE, 32'h0, 8'd0};
        dir_table[2]  = '{OP_DELETE,   7'd0,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 8'd0};
        dir_table[3]  = '{OP_INSERT,   7'd1,   32'h0000_0009, 1'b1, ST_RANGE, 32'h0, 8'd0};
        dir_table[4]  = '{OP_INSERT,   7'd0,   32'h8000_0000, 1'b1, ST_DONE,  32'h0, 8'd1};
        dir_table[5]  = '{OP_APPEND,   7'd127, 32'h7fff_ffff, 1'b1, ST_DONE,  32'h0, 8'd2};
        dir_table[6]  = '{OP_READ,     7'd0,   32'h0000_0000, 1'b1, ST_DONE,
                          32'h8000_0000, 8'd2};
        dir_table[7]  = '{OP_READ,     7'd1,   32'h0000_0000, 1'b1, ST_DONE,
                          32'h7fff_ffff, 8'd2};
        dir_table[8]  = '{OP_INSERT,   7'd2,   32'hffff_ffff, 1'b1, ST_DONE,  32'h0, 8'd3};
        dir_table[9]  = '{OP_INSERT,   7'd1,   32'h0000_0000, 1'b0, ST_DONE,  32'h0, 8'd0};
        dir_table[10] = '{OP_UPDATE,   7'd3,   32'h1234_5678, 1'b0, ST_DONE,  32'h0, 8'd0};
        dir_table[11] = '{OP_READ,     7'd127, 32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 8'd4};
        dir_table[12] = '{OP_DELETE,   7'd1,   32'h0000_0000, 1'b0, ST_DONE,  32'h0, 8'd0};
        dir_table[13] = '{OP_READ,     7'd1,   32'h0000_0000, 1'b0, ST_DONE,  32'h0, 8'd0};
        dir_table[14] = '{OP_READ,     7'd3,   32'h0000_0000, 1'b0, ST_DONE,  32'h0, 8'd0};
        dir_table[15] = '{OP_UNUSED_A, 7'd127, 32'hffff_ffff, 1'b1, ST_DONE,  32'h0, 8'd3};
        dir_table[16] = '{OP_UNUSED_B, 7'd0,   32'h0000_0000, 1'b1, ST_DONE,  32'h0, 8'd3};
        dir_table[17] = '{OP_DELETE,   7'd2,   32'h0000_0000, 1'b0, ST_DONE,  32'h0, 8'd0};
        dir_table[18] = '{OP_CLEAR,    7'd5,   32'h0000_0001, 1'b1, ST_DONE,  32'h0, 8'd0};
        dir_table[19] = '{OP_READ,     7'd0,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 8'd0};
        dir_table[20] = '{OP_APPEND,   7'd0,   32'h5555_5555, 1'b0, ST_DONE,  32'h0, 8'd0};
        dir_table[21] = '{OP_INSERT,   7'd0,   32'haaaa_aaaa, 1'b0, ST_DONE,  32'h0, 8'd0};
        dir_table[22] = '{OP_DELETE,   7'd0,   32'h0000_0000, 1'b0, ST_DONE,  32'h0, 8'd0};
        dir_table[23] = '{OP_CLEAR,    7'd0,   32'h0000_0000, 1'b1, ST_DONE,  32'h0, 8'd0};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++)
        begin
            row = dir_table[k];
            drive_beat(row.op, row.pos, row.val);
            compute_list_reply(row.op, row.pos, row.val, reply);
            if (row.known)
                reply = '{row.status, row.read_value, row.length};
            replies_due.push_back(reply);
        end

        // Fill the list to capacity, then probe the full list and the longest shifts.
        while (shadow_len < DEPTH)
            send_checked(OP_APPEND, POS_W'($urandom_range(0, 127)), $urandom);
        send_checked(OP_APPEND, 7'd0,   32'h7fff_ffff);
        send_checked(OP_INSERT, 7'd127, 32'h8000_0000);
        send_checked(OP_INSERT, 7'd0,   32'h0000_0001);
        send_checked(OP_READ,   7'd127, 32'h0000_0000);
        send_checked(OP_UPDATE, 7'd127, 32'hffff_ffff);
        send_checked(OP_READ,   7'd127, 32'h0000_0000);
        send_checked(OP_DELETE, 7'd0,   32'h0000_0000);
        send_checked(OP_INSERT, 7'd0,   32'h8000_0000);
        send_checked(OP_DELETE, 7'd127, 32'h0000_0000);
        send_checked(OP_INSERT, 7'd127, 32'h7fff_ffff);
        send_checked(OP_READ,   7'd0,   32'h0000_0000);
        send_checked(OP_CLEAR,  7'd0,   32'h0000_0000);

        // Random phases, each biased to grow, shrink or churn the list.
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            mode = phase % 3;
            if (phase == 2 || phase == 7)
                hold_reqs++;
            if (phase == 4 || phase == 9)
            begin
                // Withdraw the last beat while every result drains.
                in_valid <= 1'b0;
                while (replies_due.size() != 0)
                    @(posedge clk);
            end
            case (mode)
                MODE_GROW:
                begin
                    c_app = 35; c_ins = 60; c_upd = 70; c_del = 78; c_rd = 97; c_clr = 98;
                end
                MODE_SHRINK:
                begin
                    c_app = 10; c_ins = 20; c_upd = 30; c_del = 70; c_rd = 95; c_clr = 96;
                end
                default:
                begin
                    c_app = 20; c_ins = 40; c_upd = 55; c_del = 75; c_rd = 95; c_clr = 97;
                end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < c_app)
                    op = OP_APPEND;
                else if (roll < c_ins)
                    op = OP_INSERT;
                else if (roll < c_upd)
                    op = OP_UPDATE;
                else if (roll < c_del)
                    op = OP_DELETE;
                else if (roll < c_rd)
                    op = OP_READ;
                else if (roll < c_clr)
                    op = OP_CLEAR;
                else
                    op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_A : OP_UNUSED_B;

                // Mostly an index in range; the rest is any index at all.
                lim = (op == OP_INSERT) ? shadow_len : shadow_len - 1;
                if (lim > 127)
                    lim = 127;
                if (lim >= 0 && $urandom_range(0, 9) < 8)
                    pos = POS_W'($urandom_range(0, lim));
                else
                    pos = POS_W'($urandom_range(0, 127));

                if ($urandom_range(0, 7) == 0)
                    case ($urandom_range(0, 3))
                        0:       val = 32'h8000_0000;
                        1:       val = 32'h7fff_ffff;
                        2:       val = '0;
                        default: val = '1;
                    endcase
                else
                    val = $urandom;

                send_checked(op, pos, val);
            end
        end

        // Drain, then give the block time to show any stray result beat.
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);

        if (mismatch_count == 0)
            $display("** indexed_list_insert_delete: PASSED **");
        else
            $display("** indexed_list_insert_delete: FAILED **");
        $finish;
    end

endmodule
